>>> rtl/stq_pkg.sv
// Shared types and codes for the sorted timeout timer queue.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

	localparam int NUM_TIMERS_DFLT = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	// Command codes.
	localparam logic [2:0] FN_ALLOC = 3'd0;
	localparam logic [2:0] FN_FREE = 3'd1;
	localparam logic [2:0] FN_SET_TAG = 3'd2;
	localparam logic [2:0] FN_START = 3'd3;
	localparam logic [2:0] FN_TICK = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_GRANT = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;

	// Entry status codes.
	localparam logic [1:0] ST_UNUSED = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;

	typedef struct packed {
		logic [2:0] func;
		logic [4:0] timer_id;
		logic [31:0] timeout;
		logic [31:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] entry;
		logic [31:0] tag_out;
		logic last;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/sorted_timeout_timer_queue.sv
// Sorted timeout timer queue: entry table, deadline-ordered running list and expiry sweep.
// Depends on stq_pkg for the command and result beat types and all codes.
`timescale 1ns / 1ps
`default_nettype none

// A command beat is taken when start is high and busy is low; busy stays high until the
// command has finished its work. Deadlines, tags and list links live in three memories with
// one read port each, so the walk of the link memory sets the time a command takes. Free of
// an idle entry, set tag and a tick that expires nothing finish in the cycle they are taken,
// and busy stays low; the exception is the tick that brings the count of an empty list to
// all ones, which runs the expiry sweep. Allocate scans the status bits one entry per cycle.
// Free of a running entry unlinks it from the list, and start of a running entry unlinks it
// and then re-inserts it in deadline order. A tick expires at most MAX_RESULTS timers.
// Expiry results come out on consecutive cycles, one beat each marked by result_valid, with
// last set on the final one; the receiver must take every beat as it comes. No clearing
// pass is needed after reset.
module sorted_timeout_timer_queue #(
	parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DFLT
) (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire stq_pkg::cmd_t cmd,
	output logic busy,
	output logic result_valid,
	output stq_pkg::result_t result
);
	import stq_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int IDW = (IW > 5) ? IW : 5;
	localparam logic [IW:0] NIL = {1'b1, {IW{1'b0}}};

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ALLOC = 4'd1;
	localparam logic [3:0] S_UL_RD = 4'd2;
	localparam logic [3:0] S_UL_NX = 4'd3;
	localparam logic [3:0] S_UL_WALK = 4'd4;
	localparam logic [3:0] S_REF_DT = 4'd5;
	localparam logic [3:0] S_INS_RD = 4'd6;
	localparam logic [3:0] S_INS_WALK = 4'd7;
	localparam logic [3:0] S_INS_WR2 = 4'd8;
	localparam logic [3:0] S_EXP_WALK = 4'd9;

	// Control state.
	logic [3:0] state_q, state_d;
	logic [IW:0] head_q, head_d;
	logic [31:0] tick_q, tick_d;
	logic [31:0] next_q, next_d;
	logic pend_v_q, pend_v_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [1:0] status_q [NUM_TIMERS];

	// Working registers of the current command.
	logic [IW-1:0] id_q, id_d;
	logic ins_after_q, ins_after_d;
	logic [IW:0] nid_q, nid_d;
	logic [IW:0] prev_q, prev_d;
	logic [31:0] dl_new_q, dl_new_d;
	logic [IW-1:0] scan_q, scan_d;
	logic [IW-1:0] pend_e_q, pend_e_d;
	logic [31:0] pend_tag_q, pend_tag_d;
	logic [IW:0] rd_ptr_q, rd_ptr;

	// Memories and their registered read data.
	logic [31:0] dl_mem [NUM_TIMERS];
	logic [IW:0] lk_mem [NUM_TIMERS];
	logic [31:0] tag_mem [NUM_TIMERS];
	logic [31:0] dl_rdata_q;
	logic [IW:0] lk_rdata_q;
	logic [31:0] tag_rdata_q;

	logic dl_we, lk_we, tag_we, st_we;
	logic [IW-1:0] dl_wa, lk_wa, tag_wa, st_wa;
	logic [31:0] dl_wd, tag_wd;
	logic [IW:0] lk_wd;
	logic [1:0] st_wd;

	logic res_v;
	result_t res_d;

	logic accept;
	logic [IDW-1:0] id_wide;
	logic id_ok;
	logic [IW-1:0] id_in;
	logic [31:0] tick_inc;
	logic [IDW-1:0] scan_w, pend_w;
	logic adv, stop_ins;
	logic [IW:0] stop_cur, stop_prev;
	logic hit;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign id_wide = IDW'(cmd.timer_id);
	assign id_ok = ({1'b0, id_wide} < (IDW + 1)'(NUM_TIMERS));
	assign id_in = id_wide[IW-1:0];
	assign tick_inc = tick_q + 32'd1;
	assign scan_w = IDW'(scan_q);
	assign pend_w = IDW'(pend_e_q);

	// Insert walk: move on while the new deadline is strictly later than the current one.
	assign adv = (dl_new_q > dl_rdata_q);
	assign stop_ins = !adv || lk_rdata_q[IW];
	assign stop_cur = adv ? lk_rdata_q : rd_ptr_q;
	assign stop_prev = adv ? rd_ptr_q : prev_q;

	assign hit = !rd_ptr_q[IW] && (n_q < CNT_W'(MAX_RESULTS)) && (dl_rdata_q <= tick_q);

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tick_d = tick_q;
		next_d = next_q;
		pend_v_d = pend_v_q;
		n_d = n_q;
		id_d = id_q;
		ins_after_d = ins_after_q;
		nid_d = nid_q;
		prev_d = prev_q;
		dl_new_d = dl_new_q;
		scan_d = scan_q;
		pend_e_d = pend_e_q;
		pend_tag_d = pend_tag_q;
		rd_ptr = head_q;
		dl_we = 1'b0;
		dl_wa = id_in;
		dl_wd = cmd.timeout + tick_q;
		lk_we = 1'b0;
		lk_wa = id_q;
		lk_wd = NIL;
		tag_we = 1'b0;
		tag_wa = id_in;
		tag_wd = cmd.tag;
		st_we = 1'b0;
		st_wa = id_in;
		st_wd = ST_UNUSED;
		res_v = 1'b0;
		res_d = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					id_d = id_in;
					case (cmd.func)
						FN_ALLOC: begin
							scan_d = '0;
							state_d = S_ALLOC;
						end
						FN_FREE: begin
							if (id_ok) begin
								st_we = 1'b1;
								st_wd = ST_UNUSED;
								ins_after_d = 1'b0;
								if (status_q[id_in] == ST_RUN) begin
									state_d = S_UL_RD;
								end
							end
						end
						FN_SET_TAG: begin
							tag_we = id_ok;
						end
						FN_START: begin
							if (id_ok) begin
								// The deadline is rewritten before a running entry is unlinked from the list.
								dl_we = 1'b1;
								dl_new_d = dl_wd;
								st_we = 1'b1;
								st_wd = ST_RUN;
								ins_after_d = 1'b1;
								state_d = (status_q[id_in] == ST_RUN) ? S_UL_RD : S_INS_RD;
							end
						end
						FN_TICK: begin
							tick_d = tick_inc;
							if (next_q <= tick_inc) begin
								rd_ptr = head_q;
								n_d = '0;
								pend_v_d = 1'b0;
								state_d = S_EXP_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end

			S_ALLOC: begin
				if (status_q[scan_q] == ST_UNUSED) begin
					st_we = 1'b1;
					st_wa = scan_q;
					st_wd = ST_ALLOC;
					res_v = 1'b1;
					res_d.kind = KIND_GRANT;
					res_d.entry = scan_w[4:0];
					res_d.last = 1'b1;
					state_d = S_IDLE;
				end else if (scan_q == IW'(NUM_TIMERS - 1)) begin
					res_v = 1'b1;
					res_d.kind = KIND_FULL;
					res_d.last = 1'b1;
					state_d = S_IDLE;
				end else begin
					scan_d = scan_q + IW'(1);
				end
			end

			S_UL_RD: begin
				rd_ptr = {1'b0, id_q};
				state_d = S_UL_NX;
			end

			S_UL_NX: begin
				nid_d = lk_rdata_q;
				if (head_q == {1'b0, id_q}) begin
					// The head leaves, so the next deadline comes from its successor.
					head_d = lk_rdata_q;
					rd_ptr = lk_rdata_q;
					state_d = S_REF_DT;
				end else begin
					rd_ptr = head_q;
					state_d = S_UL_WALK;
				end
			end

			S_UL_WALK: begin
				if (lk_rdata_q == {1'b0, id_q} || lk_rdata_q[IW]) begin
					lk_we = !lk_rdata_q[IW];
					lk_wa = rd_ptr_q[IW-1:0];
					lk_wd = nid_q;
					state_d = ins_after_q ? S_INS_RD : S_IDLE;
				end else begin
					rd_ptr = lk_rdata_q;
				end
			end

			S_REF_DT: begin
				next_d = rd_ptr_q[IW] ? ALL_ONES : dl_rdata_q;
				state_d = ins_after_q ? S_INS_RD : S_IDLE;
			end

			S_INS_RD: begin
				if (head_q[IW]) begin
					lk_we = 1'b1;
					lk_wa = id_q;
					lk_wd = NIL;
					head_d = {1'b0, id_q};
					next_d = dl_new_q;
					state_d = S_IDLE;
				end else begin
					rd_ptr = head_q;
					prev_d = NIL;
					state_d = S_INS_WALK;
				end
			end

			S_INS_WALK: begin
				if (stop_ins) begin
					lk_we = 1'b1;
					lk_wa = id_q;
					lk_wd = stop_cur;
					prev_d = stop_prev;
					if (stop_prev[IW]) begin
						head_d = {1'b0, id_q};
						next_d = dl_new_q;
						state_d = S_IDLE;
					end else begin
						state_d = S_INS_WR2;
					end
				end else begin
					prev_d = rd_ptr_q;
					rd_ptr = lk_rdata_q;
				end
			end

			S_INS_WR2: begin
				lk_we = 1'b1;
				lk_wa = prev_q[IW-1:0];
				lk_wd = {1'b0, id_q};
				state_d = S_IDLE;
			end

			S_EXP_WALK: begin
				// A found entry waits in the pending register, so that the beat
				// before it can be sent knowing whether it is the final one.
				res_d.kind = KIND_EXPIRED;
				res_d.entry = pend_w[4:0];
				res_d.tag_out = pend_tag_q;
				res_v = pend_v_q;
				if (hit) begin
					st_we = 1'b1;
					st_wa = rd_ptr_q[IW-1:0];
					st_wd = ST_ALLOC;
					head_d = lk_rdata_q;
					n_d = n_q + CNT_W'(1);
					pend_v_d = 1'b1;
					pend_e_d = rd_ptr_q[IW-1:0];
					pend_tag_d = tag_rdata_q;
					rd_ptr = lk_rdata_q;
				end else begin
					res_d.last = 1'b1;
					pend_v_d = 1'b0;
					next_d = rd_ptr_q[IW] ? ALL_ONES : dl_rdata_q;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NIL;
			tick_q <= '0;
			next_q <= ALL_ONES;
			pend_v_q <= 1'b0;
			n_q <= '0;
			result_valid <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				status_q[i] <= ST_UNUSED;
			end
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tick_q <= tick_d;
			next_q <= next_d;
			pend_v_q <= pend_v_d;
			n_q <= n_d;
			result_valid <= res_v;
			if (st_we) begin
				status_q[st_wa] <= st_wd;
			end
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
		ins_after_q <= ins_after_d;
		nid_q <= nid_d;
		prev_q <= prev_d;
		dl_new_q <= dl_new_d;
		scan_q <= scan_d;
		pend_e_q <= pend_e_d;
		pend_tag_q <= pend_tag_d;
		rd_ptr_q <= rd_ptr;
		result <= res_d;
	end

	// Deadline memory.
	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[dl_wa] <= dl_wd;
		end
		dl_rdata_q <= dl_mem[rd_ptr[IW-1:0]];
	end

	// Link memory.
	always_ff @(posedge clk) begin
		if (lk_we) begin
			lk_mem[lk_wa] <= lk_wd;
		end
		lk_rdata_q <= lk_mem[rd_ptr[IW-1:0]];
	end

	// Tag memory.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		tag_rdata_q <= tag_mem[rd_ptr[IW-1:0]];
	end

endmodule

`default_nettype wire

>>> rtl/stq_port_checker.sv
// Port-level checks for the sorted timeout timer queue, bound to the top level.
// Depends on stq_pkg for the beat types and codes.
`timescale 1ns / 1ps
`default_nettype none

module stq_port_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire stq_pkg::cmd_t cmd,
	input wire busy,
	input wire result_valid,
	input wire stq_pkg::result_t result
);
	import stq_pkg::*;

	// Grants and refusals are always the only beat of their command.
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_EXPIRED |-> result.last)
		else $error("allocation result without last");

	// A refused allocation carries no entry and no tag.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_FULL |-> result.entry == 5'd0 && result.tag_out == 32'd0)
		else $error("refused allocation carries data");

	// A burst of expiry beats has no gaps before its final beat.
	a_burst_dense: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside a burst of expiry beats");

	// Allocation always scans, so the block is busy in the next cycle.
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.func == FN_ALLOC |=> busy)
		else $error("allocate accepted without going busy");

endmodule

bind sorted_timeout_timer_queue stq_port_checker u_stq_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.cmd(cmd),
	.busy(busy),
	.result_valid(result_valid),
	.result(result)
);

`default_nettype wire
